/* hw/rtl/sgr_pkg.sv */
// Package: shared types, register indexes and reset values for the serial gamepad reader.
`default_nettype none
package sgr_pkg;

  localparam int BitsPerWordDef = 16;
  localparam int WordW          = 16;
  localparam int TickW          = 16;
  localparam int CfgIdxW        = 3;

  localparam logic [TickW-1:0] FastWaitRst   = 16'd10;
  localparam logic [TickW-1:0] MouseLatchRst = 16'd50;
  localparam logic [TickW-1:0] MouseHalfRst  = 16'd250;
  localparam logic [TickW-1:0] ExtGapRst     = 16'd50;
  localparam logic [TickW-1:0] ExtLowRst     = 16'd20;
  localparam logic [TickW-1:0] ExtHighRst    = 16'd400;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOUSE_MODE  = 3'd0,
    REG_FAST_WAIT   = 3'd1,
    REG_MOUSE_LATCH = 3'd2,
    REG_MOUSE_HALF  = 3'd3,
    REG_EXT_GAP     = 3'd4,
    REG_EXT_LOW     = 3'd5,
    REG_EXT_HIGH    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LATCH,
    PH_STD_LOW,
    PH_STD_HIGH,
    PH_GAP,
    PH_EXT_LOW,
    PH_EXT_HIGH
  } phase_t;

  typedef struct packed {
    logic             mouse_mode;
    logic [TickW-1:0] fast_wait_ticks;
    logic [TickW-1:0] mouse_latch_ticks;
    logic [TickW-1:0] mouse_half_ticks;
    logic [TickW-1:0] ext_gap_ticks;
    logic [TickW-1:0] ext_low_ticks;
    logic [TickW-1:0] ext_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic extended;
    logic pad1_data;
    logic pad2_data;
  } in_item_t;

  typedef struct packed {
    logic             latch_line;
    logic             clock_line;
    logic             busy_res;
    logic             done_res;
    logic [WordW-1:0] pad1_low_word;
    logic [WordW-1:0] pad2_low_word;
    logic [WordW-1:0] pad1_high_word;
    logic [WordW-1:0] pad2_high_word;
  } res_item_t;

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    at_least_one = (v == '0) ? TickW'(1) : v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sgr_in_if.sv */
// Interface: input item channel carrying one tick of pad pin levels and requests.
`default_nettype none
interface sgr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic extended;
  logic pad1_data;
  logic pad2_data;

  modport source (output valid, start_req, extended, pad1_data, pad2_data, input ready);
  modport sink   (input valid, start_req, extended, pad1_data, pad2_data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sgr_out_if.sv */
// Interface: result item channel carrying pin levels, status and pad words.
`default_nettype none
interface sgr_out_if;
  logic        valid;
  logic        ready;
  logic        latch_line;
  logic        clock_line;
  logic        busy_res;
  logic        done_res;
  logic [15:0] pad1_low_word;
  logic [15:0] pad2_low_word;
  logic [15:0] pad1_high_word;
  logic [15:0] pad2_high_word;

  modport source (output valid, latch_line, clock_line, busy_res, done_res, pad1_low_word,
                  pad2_low_word, pad1_high_word, pad2_high_word, input ready);
  modport sink   (input valid, latch_line, clock_line, busy_res, done_res, pad1_low_word,
                  pad2_low_word, pad1_high_word, pad2_high_word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sgr_cfg_if.sv */
// Interface: configuration write channel with register index and data.
`default_nettype none
interface sgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/serial_gamepad_reader.sv */
// Top level: serial gamepad reader with config registers and registered result channel.
`default_nettype none
// Reads two serial pads on a shared latch and clock line. Every accepted input item is one
// sequencer tick and yields exactly one result item with the pin levels, busy, a done pulse
// and the four pad words as they stand after that tick. An item is accepted every cycle while
// the result register is empty or being taken, so the rate is one item per clock; the single
// result register between the tick logic and the output sets that figure. Phase lengths are
// counted in items, not clocks, and follow the timing registers at each phase entry.
module serial_gamepad_reader
  import sgr_pkg::*;
#(
  parameter int BITS_PER_WORD = BitsPerWordDef
) (
  input  wire        clk,
  input  wire        rst_n,
  sgr_in_if.sink     in_if,
  sgr_out_if.source  out_if,
  sgr_cfg_if.sink    cfg_if
);

  cfg_t      cfg_r;
  res_item_t res_r;
  res_item_t res;
  in_item_t  item;
  logic      out_valid_r;
  logic      in_take;
  logic      core_busy;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign item.start_req = in_if.start_req;
  assign item.extended  = in_if.extended;
  assign item.pad1_data = in_if.pad1_data;
  assign item.pad2_data = in_if.pad2_data;

  sgr_seq #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_take),
    .item    (item),
    .cfg     (cfg_r),
    .res     (res),
    .busy    (core_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mouse_mode        <= 1'b0;
      cfg_r.fast_wait_ticks   <= FastWaitRst;
      cfg_r.mouse_latch_ticks <= MouseLatchRst;
      cfg_r.mouse_half_ticks  <= MouseHalfRst;
      cfg_r.ext_gap_ticks     <= ExtGapRst;
      cfg_r.ext_low_ticks     <= ExtLowRst;
      cfg_r.ext_high_ticks    <= ExtHighRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MOUSE_MODE:  cfg_r.mouse_mode        <= cfg_if.data[0];
        REG_FAST_WAIT:   cfg_r.fast_wait_ticks   <= cfg_if.data;
        REG_MOUSE_LATCH: cfg_r.mouse_latch_ticks <= cfg_if.data;
        REG_MOUSE_HALF:  cfg_r.mouse_half_ticks  <= cfg_if.data;
        REG_EXT_GAP:     cfg_r.ext_gap_ticks     <= cfg_if.data;
        REG_EXT_LOW:     cfg_r.ext_low_ticks     <= cfg_if.data;
        REG_EXT_HIGH:    cfg_r.ext_high_ticks    <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.latch_line     = res_r.latch_line;
  assign out_if.clock_line     = res_r.clock_line;
  assign out_if.busy_res       = res_r.busy_res;
  assign out_if.done_res       = res_r.done_res;
  assign out_if.pad1_low_word  = res_r.pad1_low_word;
  assign out_if.pad2_low_word  = res_r.pad2_low_word;
  assign out_if.pad1_high_word = res_r.pad1_high_word;
  assign out_if.pad2_high_word = res_r.pad2_high_word;

  a_latch_clock_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.latch_line |-> res_r.clock_line)
    else $error("latch driven while clock low");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input stalled with empty result register");

  a_start_latches: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !core_busy && in_if.start_req |=> res_r.latch_line && core_busy)
    else $error("start from idle did not raise latch");

  a_busy_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> res_r.busy_res == core_busy)
    else $error("reported busy disagrees with sequencer");

endmodule
`default_nettype wire

/* hw/rtl/sgr_seq.sv */
// Module: latch/clock sequencer state, shift registers and result words, one tick per step.
`default_nettype none
module sgr_seq
  import sgr_pkg::*;
#(
  parameter int BITS_PER_WORD = BitsPerWordDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output res_item_t res,
  output logic      busy
);

  localparam int BcW = $clog2(BITS_PER_WORD);
  localparam int WlW = (BITS_PER_WORD < WordW) ? BITS_PER_WORD : WordW;
  localparam logic [BcW-1:0] LastBit = BcW'(BITS_PER_WORD - 1);

  phase_t                   phase_r, phase_nxt;
  logic [TickW-1:0]         tick_r, tick_nxt;
  logic [BcW-1:0]           bit_r, bit_nxt;
  logic                     want_ext_r, want_ext_nxt;
  logic [BITS_PER_WORD-1:0] sh1_r, sh1_nxt, sh2_r, sh2_nxt;
  logic [WordW-1:0]         w0_r, w1_r, w2_r, w3_r;
  logic [WordW-1:0]         w0_nxt, w1_nxt, w2_nxt, w3_nxt;
  logic                     done_nxt;
  logic                     b1, b2;
  logic [TickW-1:0]         std_half;
  logic [WordW-1:0]         lo1, lo2;

  assign b1       = ~item.pad1_data;
  assign b2       = ~item.pad2_data;
  assign std_half = at_least_one(cfg.mouse_mode ? cfg.mouse_half_ticks : cfg.fast_wait_ticks);
  assign lo1      = WordW'(sh1_r[WlW-1:0]);
  assign lo2      = WordW'(sh2_r[WlW-1:0]);
  assign busy     = (phase_r != PH_IDLE);

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    want_ext_nxt = want_ext_r;
    sh1_nxt      = sh1_r;
    sh2_nxt      = sh2_r;
    w0_nxt       = w0_r;
    w1_nxt       = w1_r;
    w2_nxt       = w2_r;
    w3_nxt       = w3_r;
    done_nxt     = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.start_req) begin
        want_ext_nxt = item.extended;
        sh1_nxt      = '0;
        sh2_nxt      = '0;
        bit_nxt      = '0;
        phase_nxt    = PH_LATCH;
        tick_nxt     = at_least_one(cfg.mouse_mode ? cfg.mouse_latch_ticks
                                                   : cfg.fast_wait_ticks);
      end
    end else if (tick_r > TickW'(1)) begin
      tick_nxt = tick_r - TickW'(1);
    end else begin
      case (phase_r)
        PH_LATCH: begin
          phase_nxt = PH_STD_LOW;
          tick_nxt  = std_half;
        end
        PH_STD_LOW: begin
          sh1_nxt   = {b1, sh1_r[BITS_PER_WORD-1:1]};
          sh2_nxt   = {b2, sh2_r[BITS_PER_WORD-1:1]};
          phase_nxt = PH_STD_HIGH;
          tick_nxt  = std_half;
        end
        PH_STD_HIGH: begin
          if (bit_r != LastBit) begin
            bit_nxt   = bit_r + BcW'(1);
            phase_nxt = PH_STD_LOW;
            tick_nxt  = std_half;
          end else begin
            w0_nxt   = lo1;
            w1_nxt   = lo2;
            done_nxt = 1'b1;
            bit_nxt  = '0;
            if (want_ext_r && (lo1[WordW-1] || lo2[WordW-1])) begin
              sh1_nxt   = '0;
              sh2_nxt   = '0;
              phase_nxt = PH_GAP;
              tick_nxt  = at_least_one(cfg.ext_gap_ticks);
            end else begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
            end
          end
        end
        PH_GAP: begin
          phase_nxt = PH_EXT_LOW;
          tick_nxt  = at_least_one(cfg.ext_low_ticks);
        end
        PH_EXT_LOW: begin
          sh1_nxt   = {sh1_r[BITS_PER_WORD-2:0], b1};
          sh2_nxt   = {sh2_r[BITS_PER_WORD-2:0], b2};
          phase_nxt = PH_EXT_HIGH;
          tick_nxt  = at_least_one(cfg.ext_high_ticks);
        end
        PH_EXT_HIGH: begin
          if (bit_r != LastBit) begin
            bit_nxt   = bit_r + BcW'(1);
            phase_nxt = PH_EXT_LOW;
            tick_nxt  = at_least_one(cfg.ext_low_ticks);
          end else begin
            w2_nxt    = lo1;
            w3_nxt    = lo2;
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
            bit_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    res.latch_line     = (phase_nxt == PH_LATCH);
    res.clock_line     = !((phase_nxt == PH_STD_LOW) || (phase_nxt == PH_EXT_LOW));
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.done_res       = done_nxt;
    res.pad1_low_word  = w0_nxt;
    res.pad2_low_word  = w1_nxt;
    res.pad1_high_word = w2_nxt;
    res.pad2_high_word = w3_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      bit_r      <= '0;
      want_ext_r <= 1'b0;
      sh1_r      <= '0;
      sh2_r      <= '0;
      w0_r       <= '0;
      w1_r       <= '0;
      w2_r       <= '0;
      w3_r       <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      want_ext_r <= want_ext_nxt;
      sh1_r      <= sh1_nxt;
      sh2_r      <= sh2_nxt;
      w0_r       <= w0_nxt;
      w1_r       <= w1_nxt;
      w2_r       <= w2_nxt;
      w3_r       <= w3_nxt;
    end
  end

endmodule
`default_nettype wire

/* test/serial_gamepad_reader_tb.sv */
// Testbench for the serial gamepad reader: tick stimulus, per-tick prediction in item order, checks.
module serial_gamepad_reader_tb;
  import sgr_pkg::*;

  localparam int WordBits = BitsPerWordDef;
  localparam int MouseBit = 15;
  localparam int TickBatch = 16;

  typedef enum int {
    PINS_RANDOM,
    PINS_LOW,
    PINS_HIGH,
    PINS_ONE_LOW,
    PINS_TWO_LOW
  } pin_mode_t;

  logic clk;
  logic rst_n;

  sgr_in_if in_ch ();
  sgr_out_if out_ch ();
  sgr_cfg_if cfg_ch ();

  serial_gamepad_reader DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  in_item_t pending_ticks[$];
  res_item_t expected_samples[$];

  int in_idle_pct;
  int out_idle_pct;
  bit in_fire;
  int mismatches;
  int ticks_checked;
  int reads_started;
  int ext_reads;
  int reg_writes;

  cfg_t timing;
  phase_t rd_phase;
  logic [TickW-1:0] rd_ticks;
  int rd_bits;
  logic rd_want_ext;
  logic [WordBits-1:0] rd_sh1;
  logic [WordBits-1:0] rd_sh2;
  logic [WordW-1:0] rd_words [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 1000000);
    $display("status: fail");
    $finish;
  end

  function automatic logic [TickW-1:0] std_ticks();
    return timing.mouse_mode ? timing.mouse_half_ticks : timing.fast_wait_ticks;
  endfunction

  task automatic enter_phase(phase_t p, logic [TickW-1:0] n);
    rd_phase = p;
    rd_ticks = (n == '0) ? TickW'(1) : n;
  endtask

  task automatic advance_reader(input in_item_t it, output res_item_t r);
    logic b1;
    logic b2;
    logic done;
    b1 = ~it.pad1_data;
    b2 = ~it.pad2_data;
    done = 1'b0;
    if (rd_phase == PH_IDLE) begin
      if (it.start_req) begin
        rd_want_ext = it.extended;
        rd_sh1 = '0;
        rd_sh2 = '0;
        rd_bits = 0;
        reads_started++;
        enter_phase(PH_LATCH, timing.mouse_mode ? timing.mouse_latch_ticks
                                                : timing.fast_wait_ticks);
      end
    end else if (rd_ticks > 1) begin
      rd_ticks--;
    end else begin
      case (rd_phase)
        PH_LATCH: enter_phase(PH_STD_LOW, std_ticks());
        PH_STD_LOW: begin
          rd_sh1 = {b1, rd_sh1[WordBits-1:1]};
          rd_sh2 = {b2, rd_sh2[WordBits-1:1]};
          enter_phase(PH_STD_HIGH, std_ticks());
        end
        PH_STD_HIGH: begin
          rd_bits++;
          if (rd_bits < WordBits) begin
            enter_phase(PH_STD_LOW, std_ticks());
          end else begin
            rd_words[0] = rd_sh1[WordW-1:0];
            rd_words[1] = rd_sh2[WordW-1:0];
            done = 1'b1;
            if (rd_want_ext && (rd_words[0][MouseBit] || rd_words[1][MouseBit])) begin
              rd_bits = 0;
              rd_sh1 = '0;
              rd_sh2 = '0;
              ext_reads++;
              enter_phase(PH_GAP, timing.ext_gap_ticks);
            end else begin
              rd_phase = PH_IDLE;
              rd_ticks = '0;
              rd_bits = 0;
            end
          end
        end
        PH_GAP: enter_phase(PH_EXT_LOW, timing.ext_low_ticks);
        PH_EXT_LOW: begin
          rd_sh1 = {rd_sh1[WordBits-2:0], b1};
          rd_sh2 = {rd_sh2[WordBits-2:0], b2};
          enter_phase(PH_EXT_HIGH, timing.ext_high_ticks);
        end
        PH_EXT_HIGH: begin
          rd_bits++;
          if (rd_bits < WordBits) begin
            enter_phase(PH_EXT_LOW, timing.ext_low_ticks);
          end else begin
            rd_words[2] = rd_sh1[WordW-1:0];
            rd_words[3] = rd_sh2[WordW-1:0];
            done = 1'b1;
            rd_phase = PH_IDLE;
            rd_ticks = '0;
            rd_bits = 0;
          end
        end
        default: begin
          rd_phase = PH_IDLE;
          rd_ticks = '0;
        end
      endcase
    end
    r.latch_line = (rd_phase == PH_LATCH);
    r.clock_line = !(rd_phase == PH_STD_LOW || rd_phase == PH_EXT_LOW);
    r.busy_res = (rd_phase != PH_IDLE);
    r.done_res = done;
    r.pad1_low_word = rd_words[0];
    r.pad2_low_word = rd_words[1];
    r.pad1_high_word = rd_words[2];
    r.pad2_high_word = rd_words[3];
  endtask

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    in_item_t it;
    res_item_t r;
    res_item_t want;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      it.start_req = in_ch.start_req;
      it.extended = in_ch.extended;
      it.pad1_data = in_ch.pad1_data;
      it.pad2_data = in_ch.pad2_data;
      advance_reader(it, r);
      expected_samples.push_back(r);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $error("result item with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        ticks_checked++;
        check_field("latch_line", WordW'(want.latch_line), WordW'(out_ch.latch_line));
        check_field("clock_line", WordW'(want.clock_line), WordW'(out_ch.clock_line));
        check_field("busy_res", WordW'(want.busy_res), WordW'(out_ch.busy_res));
        check_field("done_res", WordW'(want.done_res), WordW'(out_ch.done_res));
        check_field("pad1_low_word", want.pad1_low_word, out_ch.pad1_low_word);
        check_field("pad2_low_word", want.pad2_low_word, out_ch.pad2_low_word);
        check_field("pad1_high_word", want.pad1_high_word, out_ch.pad1_high_word);
        check_field("pad2_high_word", want.pad2_high_word, out_ch.pad2_high_word);
      end
    end
  end

  always @(negedge clk) begin
    in_item_t t;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_fire)) begin
      if (pending_ticks.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        t = pending_ticks.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.start_req <= t.start_req;
        in_ch.extended <= t.extended;
        in_ch.pad1_data <= t.pad1_data;
        in_ch.pad2_data <= t.pad2_data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic push_tick(logic s, logic e, pin_mode_t mode);
    in_item_t t;
    t.start_req = s;
    t.extended = e;
    case (mode)
      PINS_LOW: begin
        t.pad1_data = 1'b0;
        t.pad2_data = 1'b0;
      end
      PINS_HIGH: begin
        t.pad1_data = 1'b1;
        t.pad2_data = 1'b1;
      end
      PINS_ONE_LOW: begin
        t.pad1_data = 1'b0;
        t.pad2_data = 1'b1;
      end
      PINS_TWO_LOW: begin
        t.pad1_data = 1'b1;
        t.pad2_data = 1'b0;
      end
      default: begin
        t.pad1_data = 1'($urandom_range(1));
        t.pad2_data = 1'($urandom_range(1));
      end
    endcase
    pending_ticks.push_back(t);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (!(pending_ticks.size() == 0 && !in_ch.valid && expected_samples.size() == 0));
  endtask

  // run the sequencer back to idle with start held low
  task automatic settle(pin_mode_t mode);
    int k;
    drain();
    while (rd_phase != PH_IDLE) begin
      for (k = 0; k < TickBatch; k++) push_tick(1'b0, 1'($urandom_range(1)), mode);
      drain();
    end
  endtask

  task automatic start_read(logic e, pin_mode_t mode);
    push_tick(1'b1, e, mode);
    settle(mode);
  endtask

  task automatic random_ticks(int n);
    int k;
    for (k = 0; k < n; k++) begin
      push_tick($urandom_range(3) == 0, $urandom_range(3) != 0, PINS_RANDOM);
    end
    settle(PINS_RANDOM);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [TickW-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    case (idx)
      REG_MOUSE_MODE: timing.mouse_mode = v[0];
      REG_FAST_WAIT: timing.fast_wait_ticks = v;
      REG_MOUSE_LATCH: timing.mouse_latch_ticks = v;
      REG_MOUSE_HALF: timing.mouse_half_ticks = v;
      REG_EXT_GAP: timing.ext_gap_ticks = v;
      REG_EXT_LOW: timing.ext_low_ticks = v;
      REG_EXT_HIGH: timing.ext_high_ticks = v;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(logic mm, logic [TickW-1:0] fast, logic [TickW-1:0] mlatch,
                           logic [TickW-1:0] mhalf, logic [TickW-1:0] gap,
                           logic [TickW-1:0] lo, logic [TickW-1:0] hi);
    repeat (4) @(negedge clk);
    write_reg(REG_MOUSE_MODE, {15'd0, mm});
    write_reg(REG_FAST_WAIT, fast);
    write_reg(REG_MOUSE_LATCH, mlatch);
    write_reg(REG_MOUSE_HALF, mhalf);
    write_reg(REG_EXT_GAP, gap);
    write_reg(REG_EXT_LOW, lo);
    write_reg(REG_EXT_HIGH, hi);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.extended = 1'b0;
    in_ch.pad1_data = 1'b1;
    in_ch.pad2_data = 1'b1;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MOUSE_MODE;
    cfg_ch.data = '0;
    in_fire = 1'b0;
    mismatches = 0;
    ticks_checked = 0;
    reads_started = 0;
    ext_reads = 0;
    reg_writes = 0;
    timing.mouse_mode = 1'b0;
    timing.fast_wait_ticks = FastWaitRst;
    timing.mouse_latch_ticks = MouseLatchRst;
    timing.mouse_half_ticks = MouseHalfRst;
    timing.ext_gap_ticks = ExtGapRst;
    timing.ext_low_ticks = ExtLowRst;
    timing.ext_high_ticks = ExtHighRst;
    rd_phase = PH_IDLE;
    rd_ticks = '0;
    rd_bits = 0;
    rd_want_ext = 1'b0;
    rd_sh1 = '0;
    rd_sh2 = '0;
    for (int i = 0; i < 4; i++) rd_words[i] = '0;
    in_idle_pct = 27;
    out_idle_pct = 80;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    configure(1'b0, 16'd1, 16'd3, 16'd3, 16'd0, 16'd1, 16'd1);
    start_read(1'b1, PINS_ONE_LOW);
    start_read(1'b1, PINS_TWO_LOW);
    start_read(1'b1, PINS_HIGH);
    start_read(1'b0, PINS_LOW);
    random_ticks(30);

    in_idle_pct = 80;
    out_idle_pct = 27;
    configure(1'b1, 16'hFFFF, 16'd2, 16'd1, 16'd3, 16'd2, 16'd1);
    random_ticks(30);
    configure(1'b1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd3);
    random_ticks(30);

    in_idle_pct = 0;
    out_idle_pct = 0;
    configure(1'b0, 16'd2, 16'hFFFF, 16'hFFFF, 16'd2, 16'd1, 16'd2);
    random_ticks(30);
    configure(1'b0, 16'd0, 16'd1, 16'd1, 16'd4, 16'd0, 16'd1);
    random_ticks(30);

    drain();
    repeat (20) @(posedge clk);
    $display("summary: %0d ticks checked over %0d reads, %0d with extended bits",
             ticks_checked, reads_started, ext_reads);
    $display("summary: %0d register writes across five timing settings", reg_writes);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
